/* hdl/dal_pkg.sv */
// Shared types and constants for the dense list engine.
`timescale 1ns / 1ps
`default_nettype none
package dal_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_UPDATE = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_DUMP   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  data;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [DATA_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

endpackage
`default_nettype wire

/* hdl/dal_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/dal_ctrl.sv */
// Sequencer for the dense list engine: decode, shift on delete, dump walk.
`timescale 1ns / 1ps
`default_nettype none
module dal_ctrl
  import dal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_mode,
  input  wire logic [POS_W-1:0]  in_position_in,
  input  wire logic [DATA_W-1:0] in_data_in,
  input  wire logic              emit_ok,
  output logic                   res_load,
  output res_t                   res,
  output ram_req_t               ram_req,
  input  wire logic [DATA_W-1:0] ram_rdata
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_RESP      = 5'b00010,
    S_DEL_FIRST = 5'b00100,
    S_DEL_SHIFT = 5'b01000,
    S_DUMP      = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]  ptr_r, ptr_nxt;
  res_t               res_r, res_nxt;

  logic [CNT_W-1:0]   in_pos_ext;
  logic [CNT_W-1:0]   pos_plus1;
  logic [CNT_W-1:0]   ptr_plus1;
  logic [CNT_W-1:0]   ptr_plus2;

  assign in_pos_ext = CNT_W'(in_position_in);
  assign pos_plus1  = CNT_W'(pos_r) + CNT_W'(1);
  assign ptr_plus1  = CNT_W'(ptr_r) + CNT_W'(1);
  assign ptr_plus2  = CNT_W'(ptr_r) + CNT_W'(2);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ptr_nxt   = ptr_r;
    res_nxt   = res_r;
    res_load  = 1'b0;
    res       = res_r;
    ram_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt = in_position_in;
          res_nxt = '{status: ST_OK, data: '0, pos: '0, count: count_r, last: 1'b1};
          unique case (mode_t'(in_mode))
            MODE_CLEAR: begin
              count_nxt     = '0;
              res_nxt.count = '0;
              state_nxt     = S_RESP;
            end
            MODE_APPEND: begin
              if (count_r >= CAP_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count_r[ADDR_W-1:0];
                ram_req.wdata = in_data_in;
                count_nxt     = count_r + CNT_W'(1);
                res_nxt.data  = in_data_in;
                res_nxt.pos   = POS_W'(count_r);
                res_nxt.count = count_r + CNT_W'(1);
              end
              state_nxt = S_RESP;
            end
            MODE_UPDATE, MODE_DELETE: begin
              res_nxt.pos = in_position_in;
              state_nxt   = S_RESP;
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else if (in_pos_ext >= count_r) begin
                res_nxt.status = ST_RANGE;
              end else if (mode_t'(in_mode) == MODE_UPDATE) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = in_position_in[ADDR_W-1:0];
                ram_req.wdata = in_data_in;
                res_nxt.data  = in_data_in;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = in_position_in[ADDR_W-1:0];
                res_nxt.count = count_r - CNT_W'(1);
                state_nxt     = S_DEL_FIRST;
              end
            end
            MODE_DUMP: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                ptr_nxt       = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RESP: begin
        if (emit_ok) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DEL_FIRST: begin
        res_nxt.data = ram_rdata;
        if (pos_plus1 < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = pos_plus1[ADDR_W-1:0];
          ptr_nxt       = pos_r[ADDR_W-1:0];
          state_nxt     = S_DEL_SHIFT;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_DEL_SHIFT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r;
        ram_req.wdata = ram_rdata;
        if (ptr_plus2 < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_plus2[ADDR_W-1:0];
          ptr_nxt       = ptr_plus1[ADDR_W-1:0];
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_DUMP: begin
        res.status = ST_OK;
        res.data   = ram_rdata;
        res.pos    = POS_W'(ptr_r);
        res.count  = count_r;
        res.last   = (ptr_plus1 == count_r);
        if (emit_ok) begin
          res_load = 1'b1;
          if (ptr_plus1 == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = ptr_plus1[ADDR_W-1:0];
            ptr_nxt       = ptr_plus1[ADDR_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pos_r <= pos_nxt;
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

/* hdl/dense_array_list_engine.sv */
// Top level of the dense list engine: entry RAM, sequencer and result register.
//
// Input channel (in_valid/in_ready) takes one transaction of mode, index and value;
// result channel (out_valid/out_ready) returns status, value, index, count and last.
// One input is worked on at a time; in_ready is high while the sequencer is idle,
// even when a finished result still sits in the output register.
// From acceptance to the result register: clear, append, update and all error
// cases pass through the response state; delete reads the removed entry, then
// shifts each later entry down, one RAM read and write per shifted entry; dump
// reads entry 0 first and then loads one result per cycle while the receiver
// keeps up, one RAM read each. The next input is taken only after the final
// result of the previous one is loaded, so a dump or a delete near index 0
// holds off new inputs while it walks the list.
// Reset clears the entry count and the output valid flag; the RAM contents are not
// cleared and need no clearing pass, as only entries below the count are read.
// When the receiver stalls, the result register holds and the sequencer waits
// before loading the next result; a dump resumes without losing entries.
`timescale 1ns / 1ps
`default_nettype none
module dense_array_list_engine
  import dal_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               in_mode,
  input  wire logic [POS_W-1:0]         in_position_in,
  input  wire logic signed [DATA_W-1:0] in_data_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_data_out,
  output logic [POS_W-1:0]              out_position_out,
  output logic [CNT_W-1:0]              out_count_out,
  output logic                          out_last
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  res_t              res;
  logic              res_load;
  logic              emit_ok;
  logic              out_valid_r;
  res_t              out_r;

  assign emit_ok = !out_valid_r || out_ready;

  dal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  dal_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_position_in (in_position_in),
    .in_data_in     (in_data_in),
    .emit_ok        (emit_ok),
    .res_load       (res_load),
    .res            (res),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_data_out     = out_r.data;
  assign out_position_out = out_r.pos;
  assign out_count_out    = out_r.count;
  assign out_last         = out_r.last;

endmodule
`default_nettype wire

/* hdl/dal_checker.sv */
// Port-level checks for the dense list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dal_checker
  import dal_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [2:0]        in_mode,
  input wire logic [POS_W-1:0]  in_position_in,
  input wire logic [DATA_W-1:0] in_data_in,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_status,
  input wire logic [DATA_W-1:0] out_data_out,
  input wire logic [POS_W-1:0]  out_position_out,
  input wire logic [CNT_W-1:0]  out_count_out,
  input wire logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_status) && $stable(out_last) && $stable(out_position_out))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error result not marked last");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_count_out == CAP_CNT))
    else $error("full reported below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count_out == '0))
    else $error("empty reported with entries present");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_mode)
      && $stable(in_position_in) && $stable(in_data_in))
    else $error("input transaction changed while waiting");

endmodule

bind dense_array_list_engine dal_checker u_dal_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_mode          (in_mode),
  .in_position_in   (in_position_in),
  .in_data_in       (in_data_in),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_data_out     (out_data_out),
  .out_position_out (out_position_out),
  .out_count_out    (out_count_out),
  .out_last         (out_last)
);
`default_nettype wire
